// ----- sv/rrbs_pkg.sv -----
`timescale 1ns / 1ps
package rrbs_pkg;

   localparam int SETS_DEFAULT          = 2048;
   localparam int WAYS_DEFAULT          = 16;
   localparam int WINDOW_DEFAULT        = 8;
   localparam int LEADERS_DEFAULT       = 32;
   localparam int SELECTOR_BITS_DEFAULT = 10;

   localparam int SET_FIELD_W = 16;
   localparam int WAY_FIELD_W = 5;

   localparam logic        OP_VICTIM  = 1'b0;
   localparam logic        OP_UPDATE  = 1'b1;
   localparam logic [1:0]  ACC_LOAD   = 2'd0;
   localparam logic [1:0]  RRPV_TOP   = 2'd3;
   localparam logic [1:0]  RRPV_LONG  = 2'd2;
   localparam logic [15:0] LFSR_SEED  = 16'h0001;
   localparam logic [15:0] LFSR_MASK  = 16'hB400;

   typedef struct packed {
      logic        op;
      logic [10:0] set_index;
      logic [3:0]  way;
      logic [47:0] paddr;
      logic        hit;
      logic [1:0]  access_type;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic       bypass;
   } rsp_type;

   typedef struct packed {
      logic                   op;
      logic [SET_FIELD_W-1:0] set_index;
      logic [WAY_FIELD_W-1:0] way;
      logic [7:0]             blk;
      logic                   hit;
      logic                   demand;
      logic                   srrip_lead;
      logic                   brrip_lead;
   } cmd_type;

endpackage

// ----- sv/rrbs_front.sv -----
`timescale 1ns / 1ps
module rrbs_front #(
   parameter int SETS    = rrbs_pkg::SETS_DEFAULT,
   parameter int WAYS    = rrbs_pkg::WAYS_DEFAULT,
   parameter int LEADERS = rrbs_pkg::LEADERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rrbs_pkg::req_type req_data,
   output logic              cmd_valid,
   output rrbs_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   function automatic logic [16:0] set_mod(input logic [10:0] s);
      logic [16:0] r;
      r = {6'd0, s};
      for (int k = 5; k >= 0; k--) begin
         if ((SETS << k) <= 2047 && r >= 17'(SETS << k)) begin
            r = r - 17'(SETS << k);
         end
      end
      return r;
   endfunction

   function automatic logic [5:0] way_mod(input logic [3:0] w);
      logic [5:0] r;
      r = {2'd0, w};
      for (int k = 3; k >= 0; k--) begin
         if ((WAYS << k) <= 15 && r >= 6'(WAYS << k)) begin
            r = r - 6'(WAYS << k);
         end
      end
      return r;
   endfunction

   rrbs_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   rrbs_pkg::cmd_type new_cmd;
   logic [16:0]       set_r;
   logic [5:0]        way_r;
   logic              push_ok;

   assign set_r = set_mod(req_data.set_index);
   assign way_r = way_mod(req_data.way);

   always_comb begin
      new_cmd.op         = req_data.op;
      new_cmd.set_index  = set_r[rrbs_pkg::SET_FIELD_W-1:0];
      new_cmd.way        = way_r[rrbs_pkg::WAY_FIELD_W-1:0];
      new_cmd.blk        = req_data.paddr[13:6];
      new_cmd.hit        = req_data.hit;
      new_cmd.demand     = req_data.access_type == rrbs_pkg::ACC_LOAD;
      new_cmd.srrip_lead = {1'b0, set_r} < 18'(LEADERS);
      new_cmd.brrip_lead = ({1'b0, set_r} + 18'(LEADERS)) >= 18'(SETS);
   end

   assign req_full  = count_ff == 2'd2;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = count_ff != 2'd0;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/rrbs_exec.sv -----
`timescale 1ns / 1ps
module rrbs_exec #(
   parameter int SETS          = rrbs_pkg::SETS_DEFAULT,
   parameter int WAYS          = rrbs_pkg::WAYS_DEFAULT,
   parameter int WINDOW        = rrbs_pkg::WINDOW_DEFAULT,
   parameter int SELECTOR_BITS = rrbs_pkg::SELECTOR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  rrbs_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rrbs_pkg::rsp_type rsp_data
);

   localparam int SET_W  = $clog2(SETS);
   localparam int WAY_W  = $clog2(WAYS);
   localparam int PTR_W  = $clog2(WINDOW);
   localparam int ROW_W  = 2 * WAYS;
   localparam int RING_W = 8 * WINDOW;
   localparam int DET_W  = 1 + PTR_W + RING_W + 8;
   localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
   localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MODIFY} state_type;

   logic [ROW_W-1:0] rrpv_mem [SETS];
   logic [DET_W-1:0] det_mem  [SETS];

   state_type              state_ff;
   logic [SET_W-1:0]       clr_ff;
   rrbs_pkg::cmd_type      cmd_ff;
   logic [ROW_W-1:0]       row_ff;
   logic [DET_W-1:0]       det_ff;
   logic [SELECTOR_BITS-1:0] sel_ff, sel_in;
   logic [15:0]            lfsr_ff, lfsr_in;
   logic                   out_valid_ff;
   rrbs_pkg::rsp_type      out_ff;

   logic               flag_old;
   logic [PTR_W-1:0]   ptr_old, ptr_new;
   logic [RING_W-1:0]  ring_old, ring_new;
   logic [7:0]         last_old, delta;
   logic               st;
   logic [2:0]         has;
   logic [1:0]         add;
   logic [ROW_W-1:0]   aged_row, upd_row, wr_row;
   logic [DET_W-1:0]   wr_det;
   logic [rrbs_pkg::WAY_FIELD_W-1:0] victim;
   logic               use_brrip;
   logic [15:0]        lfsr_step;
   logic [SELECTOR_BITS-1:0] sel_up;
   logic [WAY_W-1:0]   w;
   logic               stall, done, wr_en;
   logic [SET_W-1:0]   wr_addr;

   assign {flag_old, ptr_old, ring_old, last_old} = det_ff;
   assign w = cmd_ff.way[WAY_W-1:0];

   assign cmd_pop   = state_ff == S_IDLE && cmd_valid;
   assign stall     = cmd_ff.op == rrbs_pkg::OP_VICTIM && out_valid_ff && !rsp_pop;
   assign done      = state_ff == S_MODIFY && !stall;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      has = 3'b000;
      for (int i = 0; i < WAYS; i++) begin
         has[0] = has[0] | (row_ff[2*i +: 2] == 2'd1);
         has[1] = has[1] | (row_ff[2*i +: 2] == 2'd2);
         has[2] = has[2] | (row_ff[2*i +: 2] == rrbs_pkg::RRPV_TOP);
      end
      add = has[2] ? 2'd0 : has[1] ? 2'd1 : has[0] ? 2'd2 : 2'd3;
      victim = '0;
      for (int i = 0; i < WAYS; i++) begin
         aged_row[2*i +: 2] = row_ff[2*i +: 2] + add;
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (aged_row[2*i +: 2] == rrbs_pkg::RRPV_TOP) begin
            victim = rrbs_pkg::WAY_FIELD_W'(i);
         end
      end

      delta = cmd_ff.blk - last_old;
      for (int i = 0; i < WINDOW; i++) begin
         ring_new[8*i +: 8] = (ptr_old == PTR_W'(i)) ? delta : ring_old[8*i +: 8];
      end
      st = 1'b1;
      for (int i = 0; i < WINDOW; i++) begin
         if (ring_new[8*i +: 8] != ring_new[7:0]
             || !(ring_new[8*i +: 8] <= 8'd2 || ring_new[8*i +: 8] >= 8'd254)) begin
            st = 1'b0;
         end
      end
      ptr_new = (ptr_old == PTR_W'(WINDOW - 1)) ? '0 : ptr_old + PTR_W'(1);

      lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? rrbs_pkg::LFSR_MASK : 16'd0);
      use_brrip = cmd_ff.brrip_lead || (!cmd_ff.srrip_lead && sel_ff < SEL_MID);
      upd_row = row_ff;
      if (cmd_ff.hit) begin
         upd_row[2*w +: 2] = 2'd0;
      end else if (use_brrip && lfsr_step[4:0] != 5'd0) begin
         upd_row[2*w +: 2] = rrbs_pkg::RRPV_TOP;
      end else begin
         upd_row[2*w +: 2] = rrbs_pkg::RRPV_LONG;
      end

      lfsr_in = lfsr_ff;
      sel_in  = sel_ff;
      sel_up  = (cmd_ff.srrip_lead && sel_ff < SEL_MAX) ? sel_ff + 1'b1 : sel_ff;
      if (done && cmd_ff.op == rrbs_pkg::OP_UPDATE && !st) begin
         if (!cmd_ff.hit && use_brrip) begin
            lfsr_in = lfsr_step;
         end
         if (cmd_ff.hit && cmd_ff.demand) begin
            sel_in = (cmd_ff.brrip_lead && sel_up != '0) ? sel_up - 1'b1 : sel_up;
         end
      end

      if (state_ff == S_CLEAR) begin
         wr_row = '1;
         wr_det = '0;
      end else if (cmd_ff.op == rrbs_pkg::OP_VICTIM) begin
         wr_row = flag_old ? row_ff : aged_row;
         wr_det = det_ff;
      end else begin
         wr_row = st ? row_ff : upd_row;
         wr_det = {st, ptr_new, ring_new, cmd_ff.blk};
      end
      wr_en   = state_ff == S_CLEAR || done;
      wr_addr = (state_ff == S_CLEAR) ? clr_ff : cmd_ff.set_index[SET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rrpv_mem[wr_addr] <= wr_row;
         det_mem[wr_addr]  <= wr_det;
      end
      if (cmd_pop) begin
         row_ff <= rrpv_mem[cmd.set_index[SET_W-1:0]];
         det_ff <= det_mem[cmd.set_index[SET_W-1:0]];
         cmd_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (done && cmd_ff.op == rrbs_pkg::OP_VICTIM) begin
         out_ff.victim_way <= flag_old ? 4'd0 : victim[3:0];
         out_ff.bypass     <= flag_old;
      end
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sel_ff       <= SEL_MID;
         lfsr_ff      <= rrbs_pkg::LFSR_SEED;
         out_valid_ff <= 1'b0;
      end else begin
         sel_ff  <= sel_in;
         lfsr_ff <= lfsr_in;
         if (done && cmd_ff.op == rrbs_pkg::OP_VICTIM) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + SET_W'(1);
               if (clr_ff == SET_W'(SETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  state_ff <= S_MODIFY;
               end
            end
            S_MODIFY: begin
               if (!stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- sv/rrip_replacement_stream_bypass_core.sv -----
`timescale 1ns / 1ps
// DRRIP replacement (2-bit RRPV, SRRIP/BRRIP set dueling) with per-set stream
// bypass. A victim query returns one transaction (victim way or bypass); an
// update returns none. Each transaction passes two steps in the back end: it
// reads the set's metadata row, then modifies it and writes it back through the
// single write port. A 2-entry queue between front and back absorbs bursts, and
// a result register lets updates proceed while a result waits; the next victim
// query holds until that result is popped. After reset the back end clears
// every set of the metadata memory before it processes the first transaction;
// up to two pushes are queued meanwhile.
module rrip_replacement_stream_bypass_core #(
   parameter int SETS          = rrbs_pkg::SETS_DEFAULT,
   parameter int WAYS          = rrbs_pkg::WAYS_DEFAULT,
   parameter int WINDOW        = rrbs_pkg::WINDOW_DEFAULT,
   parameter int LEADERS       = rrbs_pkg::LEADERS_DEFAULT,
   parameter int SELECTOR_BITS = rrbs_pkg::SELECTOR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rrbs_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rrbs_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   rrbs_pkg::cmd_type cmd;

   rrbs_front #(
      .SETS    (SETS),
      .WAYS    (WAYS),
      .LEADERS (LEADERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   rrbs_exec #(
      .SETS          (SETS),
      .WAYS          (WAYS),
      .WINDOW        (WINDOW),
      .SELECTOR_BITS (SELECTOR_BITS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/tb_rrip_replacement_stream_bypass_core.sv -----
`timescale 1ns / 1ps
module tb_rrip_replacement_stream_bypass_core;

   localparam int NSETS = 2048;
   localparam int NWAYS = 16;
   localparam int NWIN = 8;
   localparam int NLEAD = 32;
   localparam logic [9:0] SEL_FULL = 10'd1023;
   localparam logic [9:0] SEL_HALF = 10'd511;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   rrbs_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rrbs_pkg::rsp_type rsp_data;

   rrip_replacement_stream_bypass_core dut (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [1:0] rrpv [NSETS][NWAYS];
   logic [7:0] last_blk [NSETS];
   logic [7:0] deltas [NSETS][NWIN];
   logic [2:0] ring_pos [NSETS];
   logic       streaming [NSETS];
   logic [9:0] selector;
   logic [15:0] lfsr;
   rrbs_pkg::rsp_type victim_q [$];
   int mismatches = 0;
   bit draining = 1'b0;

   function automatic bit near_step(logic [7:0] d);
      return d <= 8'd2 || d >= 8'd254;
   endfunction

   function automatic void track_stream(int s, logic [47:0] paddr);
      logic [7:0] blk;
      bit st;
      blk = paddr[13:6];
      deltas[s][ring_pos[s]] = blk - last_blk[s];
      last_blk[s] = blk;
      ring_pos[s] = ring_pos[s] + 3'd1;
      st = 1'b1;
      for (int i = 0; i < NWIN; i++)
         if (deltas[s][i] != deltas[s][0] || !near_step(deltas[s][i])) st = 1'b0;
      streaming[s] = st;
   endfunction

   function automatic void predict(rrbs_pkg::req_type r);
      int s;
      int w;
      logic [1:0] top;
      rrbs_pkg::rsp_type res;
      bit srrip_lead;
      bit brrip_lead;
      bit use_brrip;
      s = r.set_index;
      w = r.way;
      srrip_lead = s < NLEAD;
      brrip_lead = s + NLEAD >= NSETS;
      if (r.op == rrbs_pkg::OP_VICTIM) begin
         res = '0;
         if (streaming[s]) begin
            res.bypass = 1'b1;
         end else begin
            top = 2'd0;
            for (int i = 0; i < NWAYS; i++) if (rrpv[s][i] > top) top = rrpv[s][i];
            for (int i = 0; i < NWAYS; i++)
               rrpv[s][i] = rrpv[s][i] + (rrbs_pkg::RRPV_TOP - top);
            for (int i = NWAYS - 1; i >= 0; i--)
               if (rrpv[s][i] == rrbs_pkg::RRPV_TOP) res.victim_way = 4'(i);
         end
         victim_q.push_back(res);
         return;
      end
      track_stream(s, r.paddr);
      if (streaming[s]) return;
      if (r.hit) begin
         rrpv[s][w] = 2'd0;
      end else begin
         use_brrip = brrip_lead ? 1'b1 : srrip_lead ? 1'b0 : (selector < SEL_HALF);
         if (use_brrip) begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ rrbs_pkg::LFSR_MASK) : (lfsr >> 1);
            rrpv[s][w] = (lfsr[4:0] == 5'd0) ? rrbs_pkg::RRPV_LONG : rrbs_pkg::RRPV_TOP;
         end else begin
            rrpv[s][w] = rrbs_pkg::RRPV_LONG;
         end
      end
      if (r.hit && r.access_type == rrbs_pkg::ACC_LOAD) begin
         if (srrip_lead && selector < SEL_FULL) selector++;
         if (brrip_lead && selector > 0) selector--;
      end
   endfunction

   task automatic send(rrbs_pkg::req_type r);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict(r);
   endtask

   function automatic rrbs_pkg::req_type make(logic op, int s, int w, logic [47:0] pa,
                                              logic h, logic [1:0] t);
      rrbs_pkg::req_type r;
      r.op = op; r.set_index = 11'(s); r.way = 4'(w); r.paddr = pa; r.hit = h;
      r.access_type = t;
      return r;
   endfunction

   function automatic rrbs_pkg::req_type rand_item(int s);
      return make(logic'($urandom_range(0, 1)), s, $urandom_range(0, 15),
                  48'({$urandom, $urandom}), logic'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (victim_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", rsp_data);
         end else begin
            rrbs_pkg::rsp_type e;
            e = victim_q.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty || gap <= 0) begin
            gap = ($urandom_range(0, 3) == 0 || draining) ? 0 : $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            gap--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic test_extremes();
      send(make(rrbs_pkg::OP_VICTIM, 0, 0, '0, 1'b0, 2'd0));
      send(make(rrbs_pkg::OP_VICTIM, NSETS - 1, 0, '0, 1'b0, 2'd0));
      send(make(rrbs_pkg::OP_UPDATE, 0, 15, '1, 1'b1, 2'd0));
      send(make(rrbs_pkg::OP_UPDATE, NSETS - 1, 0, '0, 1'b1, 2'd0));
      send(make(rrbs_pkg::OP_UPDATE, 100, 15, 48'h5555_5555_5555, 1'b0, 2'd3));
      send(make(rrbs_pkg::OP_UPDATE, 100, 3, 48'hAAAA_AAAA_AAAA, 1'b1, 2'd2));
      send(make(rrbs_pkg::OP_VICTIM, 100, 0, '0, 1'b0, 2'd1));
      send(make(rrbs_pkg::OP_UPDATE, NSETS - 1, 7, 48'h40, 1'b0, 2'd1));
   endtask

   task automatic test_streams();
      logic [47:0] base;
      int s;
      int step;
      for (int k = 0; k < 3; k++) begin
         s = (k == 0) ? 5 : (k == 1) ? 777 : NSETS - 2;
         step = (k == 0) ? 1 : (k == 1) ? -2 : 0;
         base = 48'({$urandom, $urandom});
         for (int i = 0; i < 9; i++)
            send(make(rrbs_pkg::OP_UPDATE, s, i, base + 48'(64 * step * i), 1'b0, 2'd0));
         send(make(rrbs_pkg::OP_VICTIM, s, 0, '0, 1'b0, 2'd0));
         send(make(rrbs_pkg::OP_UPDATE, s, 1, base + 48'(4096), 1'b1, 2'd0));
         send(make(rrbs_pkg::OP_VICTIM, s, 0, '0, 1'b0, 2'd0));
      end
   endtask

   task automatic test_dueling();
      for (int i = 0; i < 60; i++)
         send(make(rrbs_pkg::OP_UPDATE, $urandom_range(0, NLEAD - 1), $urandom_range(0, 15),
                   48'({$urandom, $urandom}), 1'b1, rrbs_pkg::ACC_LOAD));
      for (int i = 0; i < 150; i++) begin
         if (i % 3 == 2)
            send(make(rrbs_pkg::OP_VICTIM, 300 + i % 7, 0, '0, 1'b0, 2'd0));
         else if (i % 3 == 1)
            send(make(rrbs_pkg::OP_UPDATE, 300 + i % 7, $urandom_range(0, 15),
                      48'({$urandom, $urandom}), 1'b0, 2'd0));
         else
            send(make(rrbs_pkg::OP_UPDATE, NSETS - 1 - $urandom_range(0, NLEAD - 1),
                      $urandom_range(0, 15), 48'({$urandom, $urandom}), 1'b1,
                      rrbs_pkg::ACC_LOAD));
      end
   endtask

   task automatic test_random();
      int s;
      logic [47:0] pa;
      int step;
      for (int n = 0; n < 1300; ) begin
         s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NSETS - 1)
                                          : $urandom_range(0, 15) * 130;
         if ($urandom_range(0, 4) == 0) begin
            pa = 48'({$urandom, $urandom});
            step = $urandom_range(0, 4) - 2;
            for (int i = 0; i < 10; i++) begin
               send(make(rrbs_pkg::OP_UPDATE, s, $urandom_range(0, 15),
                         pa + 48'(64 * step * i),
                         logic'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
               n++;
               if ($urandom_range(0, 2) == 0) begin
                  send(make(rrbs_pkg::OP_VICTIM, s, 0, '0, 1'b0, 2'd0));
                  n++;
               end
            end
         end else begin
            send(rand_item(s));
            n++;
         end
      end
   endtask

   initial begin
      for (int s = 0; s < NSETS; s++) begin
         for (int w = 0; w < NWAYS; w++) rrpv[s][w] = rrbs_pkg::RRPV_TOP;
         for (int i = 0; i < NWIN; i++) deltas[s][i] = 8'd0;
         last_blk[s] = 8'd0;
         ring_pos[s] = 3'd0;
         streaming[s] = 1'b0;
      end
      selector = SEL_HALF;
      lfsr = rrbs_pkg::LFSR_SEED;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_streams();
      test_dueling();
      test_random();
      req_push <= 1'b0;
      draining = 1'b1;
      while (victim_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && victim_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule
